[hdl/bdq_pkg.sv]
package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;

  // A dump reports at most this many entries.
  localparam int RESULT_CAP = 16;

  typedef logic [OP_W-1:0] op_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK = 3'd1;
  localparam op_t OP_POP_FRONT = 3'd2;
  localparam op_t OP_POP_BACK = 3'd3;
  localparam op_t OP_DUMP = 3'd4;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL = 2'd2;

endpackage

[hdl/bdq_in_if.sv]
interface bdq_in_if;
  import bdq_pkg::*;

  logic valid;
  logic ready;
  op_t operation;
  data_t item;

  modport source (output valid, output operation, output item, input ready);
  modport sink (input valid, input operation, input item, output ready);
endinterface

[hdl/bdq_out_if.sv]
interface bdq_out_if;
  import bdq_pkg::*;

  logic valid;
  logic ready;
  data_t value;
  status_t status;
  logic last;

  modport source (output valid, output value, output status, output last, input ready);
  modport sink (input valid, input value, input status, input last, output ready);
endinterface

[hdl/bounded_deque_engine_unit.sv]
// Bounded double-ended queue of signed 32-bit words held in a ring memory.
// A push result is registered from state S_ADDR, a pop result from the memory read in S_RD;
// each dumped entry passes through S_ADDR, S_RD and S_OUT in turn.
// A new input word is taken only in S_IDLE, after the last result has been handed off;
// a dump holds the input until every reported entry has gone, one memory read per entry.
// Reset (rst, synchronous, active high) empties the queue; stored words are not cleared.
module bounded_deque_engine_unit #(
  parameter int DEPTH = 16
) (
  input logic clk,
  input logic rst,
  bdq_in_if.sink in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sequencer states. The block takes a new input word only in S_IDLE.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_RD = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;

  // Queue bookkeeping: ring index of the front entry and number of stored entries.
  logic [IDX_W-1:0] front;
  logic [CNT_W-1:0] occ;

  // Captured input word and dump progress.
  op_t op;
  data_t item;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] dump_len;

  // Output register; the result stays here until the sink takes it.
  logic out_valid;
  data_t out_value;
  status_t out_status;
  logic out_last;

  // The ring memory, with a registered read port.
  data_t mem [DEPTH];
  data_t rdata;

  logic [IDX_W-1:0] offset;
  logic [IDX_W-1:0] ring_addr;
  logic is_push;
  logic is_pop;
  logic wr_en;
  logic rd_en;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.value = out_value;
  assign out_ch.status = out_status;
  assign out_ch.last = out_last;

  assign is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
  assign is_pop = (op == OP_POP_FRONT) || (op == OP_POP_BACK);

  // Every ring position goes through one shared modular adder: front plus an offset that
  // depends on the operation. In S_RD a pop from the front reuses it to step the front.
  always_comb begin
    offset = '0;
    if (state == S_RD) begin
      offset = IDX_W'(1);
    end else begin
      unique case (op)
        OP_PUSH_FRONT: offset = IDX_W'(DEPTH - 1);
        OP_PUSH_BACK: offset = occ[IDX_W-1:0];
        OP_POP_FRONT: offset = '0;
        OP_POP_BACK: offset = IDX_W'(occ - 1'b1);
        OP_DUMP: offset = cnt[IDX_W-1:0];
        default: offset = '0;
      endcase
    end
  end

  bdq_ring_addr #(
    .DEPTH(DEPTH)
  ) u_ring_addr (
    .base(front),
    .offset(offset),
    .addr(ring_addr)
  );

  // A full queue drops the push; an empty one answers pops and dumps with status only.
  assign wr_en = (state == S_ADDR) && is_push && (occ != CNT_W'(DEPTH));
  assign rd_en = (state == S_ADDR) && (is_pop || (op == OP_DUMP)) && (occ != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ring_addr] <= item;
    end
    if (rd_en) begin
      rdata <= mem[ring_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      occ <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op <= in_ch.operation;
            item <= in_ch.item;
            cnt <= '0;
            // Codes beyond the dump produce no result and leave the queue alone.
            if (in_ch.operation <= OP_DUMP) begin
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: begin
          if (is_push) begin
            out_value <= '0;
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
            if (occ == CNT_W'(DEPTH)) begin
              out_status <= ST_FULL;
            end else begin
              out_status <= ST_OK;
              occ <= occ + 1'b1;
              if (op == OP_PUSH_FRONT) begin
                front <= ring_addr;
              end
            end
          end else if (occ == '0) begin
            out_value <= '0;
            out_status <= ST_EMPTY;
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            if (occ > CNT_W'(RESULT_CAP) && DEPTH > RESULT_CAP) begin
              dump_len <= CNT_W'(RESULT_CAP);
            end else begin
              dump_len <= occ;
            end
            state <= S_RD;
          end
        end
        S_RD: begin
          out_value <= rdata;
          out_status <= ST_OK;
          out_valid <= 1'b1;
          state <= S_OUT;
          if (op == OP_DUMP) begin
            out_last <= (CNT_W'(cnt + 1'b1) == dump_len);
          end else begin
            out_last <= 1'b1;
            occ <= occ - 1'b1;
            // Removing the only entry returns the ring to its reset position.
            if (occ == CNT_W'(1)) begin
              front <= '0;
            end else if (op == OP_POP_FRONT) begin
              front <= ring_addr;
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if ((op == OP_DUMP) && !out_last) begin
              cnt <= cnt + 1'b1;
              state <= S_ADDR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/bdq_ring_addr.sv]
module bdq_ring_addr #(
  parameter int DEPTH = 16
) (
  input logic [$clog2(DEPTH)-1:0] base,
  input logic [$clog2(DEPTH)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] addr
);
  localparam int IDX_W = $clog2(DEPTH);

  logic [IDX_W:0] sum;

  // Both operands are below DEPTH, so one conditional subtract wraps the sum.
  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      addr = IDX_W'(sum - (IDX_W+1)'(DEPTH));
    end else begin
      addr = sum[IDX_W-1:0];
    end
  end
endmodule

[hdl/bdq_checker.sv]
module bdq_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input bdq_pkg::data_t out_value,
  input bdq_pkg::status_t out_status,
  input logic out_last
);
  import bdq_pkg::*;

  // An error status always carries a zero value.
  a_err_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (out_value == '0))
    else $error("error result with nonzero value");

  // An error status is always the only result of its word.
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("error result not marked last");

  // One word at a time: no input is taken while a result is pending.
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result waits");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_status)
      && $stable(out_last)))
    else $error("stalled result changed");
endmodule

bind bounded_deque_engine_unit bdq_checker u_bdq_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_value(out_ch.value),
  .out_status(out_ch.status),
  .out_last(out_ch.last)
);

[test/bounded_deque_engine_unit_tb.sv]
`timescale 1ns / 100ps

module bounded_deque_engine_unit_tb;
  import bdq_pkg::*;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);

  // Length of the receiver's hold-off during the back-pressure test.
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 160;
  // After the last expected result, wait this long for stray results.
  localparam int DRAIN_CYCLES = 24;

  // Operation codes that the block must ignore without answering.
  localparam op_t OP_UNKNOWN_FIRST = 3'd5;
  localparam op_t OP_UNKNOWN_LAST = 3'd7;

  typedef struct packed {
    data_t value;
    status_t status;
    logic last;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst;

  bdq_in_if in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_engine_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Local copy of the deque: ring storage, index of the front entry and the
  // number of stored entries. It is updated once per accepted input word.
  data_t ring [DEPTH];
  logic [IDX_W-1:0] head = '0;
  logic [IDX_W:0] fill = '0;

  // Results that the block still owes, oldest first.
  deque_result_t pending_results[$];

  bit failed = 1'b0;

  // Idling percentages for the two sides, changed between test phases.
  int idle_pct = 0;
  int stall_pct = 0;

  // Random traffic leans toward pushes while filling and toward pops while
  // draining, so that the full and empty corners are reached repeatedly.
  bit filling = 1'b1;

  logic hold_start = 1'b0;
  int hold_left = 0;

  function automatic void note_result(input data_t value, input status_t status,
                                      input logic last);
    deque_result_t res;
    res.value = value;
    res.status = status;
    res.last = last;
    pending_results.push_back(res);
  endfunction

  // Applies one accepted word to the local deque and queues what it must yield.
  function automatic void deque_apply(input op_t op, input data_t data);
    logic [IDX_W-1:0] slot;
    int n;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill == DEPTH) begin
          // A push into a full deque is dropped and reported.
          note_result('0, ST_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head = head - 1'b1;
            ring[head] = data;
          end else begin
            slot = head + fill[IDX_W-1:0];
            ring[slot] = data;
          end
          fill = fill + 1'b1;
          note_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill == 0) begin
          note_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (op == OP_POP_FRONT) begin
            slot = head;
            head = head + 1'b1;
          end else begin
            slot = head + fill[IDX_W-1:0] - 1'b1;
          end
          fill = fill - 1'b1;
          // Removing the only entry resets the ring to its initial position.
          if (fill == 0) begin
            head = '0;
          end
          note_result(ring[slot], ST_OK, 1'b1);
        end
      end
      OP_DUMP: begin
        if (fill == 0) begin
          note_result('0, ST_EMPTY, 1'b1);
        end else begin
          n = (fill > RESULT_CAP) ? RESULT_CAP : int'(fill);
          for (int k = 0; k < n; k++) begin
            slot = head + IDX_W'(k);
            note_result(ring[slot], ST_OK, k == n - 1);
          end
        end
      end
      default: begin
        // Unknown codes leave the deque alone and yield nothing.
      end
    endcase
  endfunction

  // Mostly random words, with the sign and range extremes mixed in often.
  function automatic data_t rand_item();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Offers one word, with random idle cycles ahead of it, and returns once
  // the block has taken it. Valid stays high on return so that back-to-back
  // words need no extra assignment; any other wait must lower it first.
  task automatic send_word(input op_t op, input data_t data);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.item <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    deque_apply(op, data);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // Receiver side: random stalls, or a long counted hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every word taken from the output is checked against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d last %0b", $time,
                 out_ch.value, out_ch.status, out_ch.last);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value !== want.value || out_ch.status !== want.status ||
            out_ch.last !== want.last) begin
          $display("%0t: mismatch: expected value %0d status %0d last %0b, got value %0d status %0d last %0b",
                   $time, want.value, want.status, want.last,
                   out_ch.value, out_ch.status, out_ch.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Pops and dumps on an empty deque report empty; unknown codes are ignored.
  task automatic test_empty_queue();
    set_idling(0, 0);
    send_word(OP_POP_FRONT, rand_item());
    send_word(OP_POP_BACK, rand_item());
    send_word(OP_DUMP, rand_item());
    for (int code = OP_UNKNOWN_FIRST; code <= OP_UNKNOWN_LAST; code++) begin
      send_word(op_t'(code), rand_item());
    end
  endtask

  // Ordering at both ends with extreme values, and popping the only entry
  // from either end.
  task automatic test_push_pop_order();
    send_word(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_word(OP_PUSH_BACK, 32'h8000_0000);
    send_word(OP_PUSH_FRONT, 32'h0000_0000);
    send_word(OP_PUSH_BACK, 32'hffff_ffff);
    send_word(OP_DUMP, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_PUSH_BACK, 32'h5555_5555);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_PUSH_FRONT, 32'haaaa_aaaa);
    send_word(OP_POP_BACK, '0);
  endtask

  // Fills the ring from both ends so the indexes wrap, pushes into the full
  // deque, dumps every entry and drains it down to empty again.
  task automatic test_fill_and_wrap();
    set_idling(17, 17);
    for (int i = 0; i < DEPTH; i++) begin
      send_word(i % 2 ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_item());
    end
    send_word(OP_PUSH_FRONT, rand_item());
    send_word(OP_PUSH_BACK, rand_item());
    send_word(OP_DUMP, rand_item());
    while (fill != 0) begin
      send_word(fill % 2 ? OP_POP_FRONT : OP_POP_BACK, rand_item());
    end
    send_word(OP_POP_FRONT, rand_item());
  endtask

  // The receiver stops for a long stretch while pushes keep coming, so the
  // block backs up and must stall its input without losing anything.
  task automatic test_output_hold();
    set_idling(0, 0);
    in_ch.valid <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < DEPTH + 4; i++) begin
      send_word($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_item());
    end
    send_word(OP_DUMP, rand_item());
    for (int i = 0; i < DEPTH + 4; i++) begin
      send_word($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, rand_item());
    end
  endtask

  // Random mix of all operations. Unknown codes are sent now and then but do
  // not count toward the number of words in the phase.
  task automatic run_random_phase(input int words);
    int sent;
    int pick;
    bit push;
    op_t op;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(op_t'($urandom_range(OP_UNKNOWN_LAST, OP_UNKNOWN_FIRST)), rand_item());
      end else begin
        if (pick < 12) begin
          op = OP_DUMP;
        end else begin
          push = filling ? ($urandom_range(99) < 75) : ($urandom_range(99) < 25);
          if (push) begin
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          end else begin
            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
          end
        end
        send_word(op, rand_item());
        sent++;
        // Linger at the corners for a while before turning around.
        if (fill == DEPTH && $urandom_range(1)) begin
          filling = 1'b0;
        end else if (fill == 0 && $urandom_range(1)) begin
          filling = 1'b1;
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    run_random_phase(RANDOM_WORDS / 4);
    set_idling(48, 0);
    run_random_phase(RANDOM_WORDS / 4);
    set_idling(0, 48);
    run_random_phase(RANDOM_WORDS / 4);
    set_idling(17, 17);
    run_random_phase(RANDOM_WORDS / 4);
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PUSH_FRONT;
    in_ch.item = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_push_pop_order();
    test_fill_and_wrap();
    test_output_hold();
    test_random_traffic();

    // Stop offering, wait for every owed result, then watch for strays.
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("** bounded_deque_engine_unit: PASSED **");
    end else begin
      $display("** bounded_deque_engine_unit: FAILED **");
    end
    $finish;
  end

  // A correct run takes a small fraction of this time.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("** bounded_deque_engine_unit: FAILED **");
    $finish;
  end

endmodule
